// ===== rtl/core/hdrtm_pkg.sv =====
// Package with the shared types, constants and gamma table of the HDR tonemapper.
`default_nettype none
package hdrtm_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int INT_BITS       = 8;
   localparam int GAMMA_LUT_BITS = 10;

   localparam int CH_BITS   = INT_BITS + FRAC_BITS;
   localparam int LANES     = 3;
   localparam int LUT_N     = 1 << GAMMA_LUT_BITS;
   localparam int LUT_SIZE  = LUT_N + 1;
   localparam int ROM_BITS  = FRAC_BITS + 1;
   localparam int IDX_BITS  = GAMMA_LUT_BITS + 1;
   localparam int POS_BITS  = ROM_BITS + GAMMA_LUT_BITS;

   localparam int COEF_BITS = 18;
   localparam int T_BITS    = COEF_BITS + CH_BITS + 1;
   localparam int T_LO      = T_BITS / 2;
   localparam int T_HI      = T_BITS - T_LO;
   localparam int PL_BITS   = T_LO + CH_BITS;
   localparam int PH_BITS   = T_HI + CH_BITS;
   localparam int P_BITS    = T_BITS + CH_BITS + 1;
   localparam int PROD_BITS = ROM_BITS + FRAC_BITS;

   localparam logic [COEF_BITS-1:0] ACES_A = COEF_BITS'(164495);
   localparam logic [COEF_BITS-1:0] ACES_B = COEF_BITS'(1966);
   localparam logic [COEF_BITS-1:0] ACES_C = COEF_BITS'(159252);
   localparam logic [COEF_BITS-1:0] ACES_D = COEF_BITS'(38666);
   localparam logic [COEF_BITS-1:0] ACES_E = COEF_BITS'(9175);

   localparam logic [1:0] MODE_PASS     = 2'd0;
   localparam logic [1:0] MODE_REINHARD = 2'd1;
   localparam logic [1:0] MODE_ACES     = 2'd2;

   localparam int ST_IN   = 0;
   localparam int ST_COEF = 1;
   localparam int ST_PART = 2;
   localparam int ST_SUM  = 3;
   localparam int ST_CMP  = 4;
   localparam int ST_ROM  = ST_CMP + FRAC_BITS + 1;
   localparam int ST_MUL  = ST_ROM + 1;
   localparam int ST_ADD  = ST_MUL + 1;
   localparam int NSTAGE  = ST_ADD + 1;

   localparam int POW_BITS  = 11 * (FRAC_BITS + 2);
   localparam int ROM_SHIFT = 11 * FRAC_BITS + 11 - 5 * GAMMA_LUT_BITS;

   typedef struct packed {
      logic [CH_BITS-1:0] red_in;
      logic [CH_BITS-1:0] green_in;
      logic [CH_BITS-1:0] blue_in;
   } hdrtm_req_type;

   typedef struct packed {
      logic [CH_BITS-1:0] red_out;
      logic [CH_BITS-1:0] green_out;
      logic [CH_BITS-1:0] blue_out;
   } hdrtm_rsp_type;

   typedef struct packed {
      logic [NSTAGE-1:0] load;
      logic              out_load;
   } hdrtm_ctl_type;

   typedef logic [ROM_BITS-1:0] gamma_rom_type [LUT_SIZE];

   // Each entry is the largest y with (2y-1)^11 <= i^5 scaled, which is the
   // exactly rounded value of the gamma curve at that point.
   function automatic gamma_rom_type build_gamma_rom();
      gamma_rom_type       rom;
      logic [POW_BITS-1:0] target;
      logic [POW_BITS-1:0] p;
      logic [POW_BITS-1:0] m;
      longint              lo;
      longint              hi;
      longint              mid;
      for (int i = 0; i < LUT_SIZE; i++) begin
         target = POW_BITS'(i);
         for (int k = 0; k < 4; k++) begin
            target = target * POW_BITS'(i);
         end
         target = target << ROM_SHIFT;
         lo = 0;
         hi = longint'(1) << FRAC_BITS;
         for (int s = 0; s < FRAC_BITS + 2; s++) begin
            if (lo < hi) begin
               mid = lo + ((hi - lo + 1) >> 1);
               m = POW_BITS'(2 * mid - 1);
               p = POW_BITS'(1);
               for (int k = 0; k < 11; k++) begin
                  p = p * m;
               end
               if (p <= target) begin
                  lo = mid;
               end else begin
                  hi = mid - 1;
               end
            end
         end
         rom[i] = ROM_BITS'(lo);
      end
      return rom;
   endfunction

   localparam gamma_rom_type GAMMA_ROM = build_gamma_rom();

endpackage
`default_nettype wire

// ===== rtl/core/hdrtm_ctrl.sv =====
// Pipeline control: stage valid bits, per-stage load enables and the result valid.
`default_nettype none
module hdrtm_ctrl
   import hdrtm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output hdrtm_ctl_type      ctl
);

   logic [NSTAGE-1:0] valid_ff;
   logic              out_valid_ff;
   logic [NSTAGE:0]   load;

   // A stage may load when the output can move or any stage at or after it is empty.
   always_comb begin
      load[NSTAGE] = !out_valid_ff || rsp_ready;
      for (int k = 0; k < NSTAGE; k++) begin
         load[k] = load[NSTAGE] || (((~valid_ff) >> k) != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NSTAGE; k++) begin
            if (load[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
         if (load[NSTAGE]) begin
            out_valid_ff <= valid_ff[NSTAGE-1];
         end
      end
   end

   assign req_ready    = load[0];
   assign rsp_valid    = out_valid_ff;
   assign ctl.load     = load[NSTAGE-1:0];
   assign ctl.out_load = load[NSTAGE];

endmodule
`default_nettype wire

// ===== rtl/core/hdrtm_lane.sv =====
// One color channel: curve terms, pipelined restoring divider and gamma interpolation.
`default_nettype none
module hdrtm_lane
   import hdrtm_pkg::*;
(
   input  wire logic               clock,
   input  wire hdrtm_ctl_type      ctl,
   input  wire logic [1:0]         mode,
   input  wire logic [CH_BITS-1:0] x_in,
   output logic [CH_BITS-1:0]      x_out,
   output logic [ROM_BITS-1:0]     y_out
);

   logic [CH_BITS-1:0]   x_ff [NSTAGE];
   logic [T_BITS-1:0]    t1_ff;
   logic [T_BITS-1:0]    t2_ff;
   logic [T_BITS-1:0]    t1_in;
   logic [T_BITS-1:0]    t2_in;
   logic [PL_BITS-1:0]   pn_lo_ff;
   logic [PH_BITS-1:0]   pn_hi_ff;
   logic [PL_BITS-1:0]   pd_lo_ff;
   logic [PH_BITS-1:0]   pd_hi_ff;
   logic [P_BITS-1:0]    num_ff;
   logic [P_BITS-1:0]    den_sum_ff;
   logic [P_BITS-1:0]    num_in;
   logic [P_BITS-1:0]    den_sum_in;
   logic [P_BITS-1:0]    rem_ff [FRAC_BITS];
   logic [P_BITS-1:0]    den_ff [FRAC_BITS];
   logic [FRAC_BITS-1:0] q_ff [FRAC_BITS+1];
   logic                 sat_ff [FRAC_BITS+1];
   logic [ROM_BITS-1:0]  v_in;
   logic [POS_BITS-1:0]  pos;
   logic [IDX_BITS-1:0]  idx;
   logic [IDX_BITS-1:0]  idx_hi;
   logic [ROM_BITS-1:0]  lo_ff;
   logic [ROM_BITS-1:0]  hi_ff;
   logic [FRAC_BITS-1:0] f_ff;
   logic [ROM_BITS-1:0]  base_ff;
   logic [PROD_BITS-1:0] prod_ff;
   logic [PROD_BITS-1:0] prod_in;
   logic [ROM_BITS-1:0]  y_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[ST_IN]) begin
         x_ff[0] <= x_in;
      end
      for (int k = 1; k < NSTAGE; k++) begin
         if (ctl.load[k]) begin
            x_ff[k] <= x_ff[k-1];
         end
      end
   end

   assign t1_in = T_BITS'(ACES_A) * T_BITS'(x_ff[ST_IN])
                + (T_BITS'(ACES_B) << FRAC_BITS);
   assign t2_in = T_BITS'(ACES_C) * T_BITS'(x_ff[ST_IN])
                + (T_BITS'(ACES_D) << FRAC_BITS);

   always_ff @(posedge clock) begin
      if (ctl.load[ST_COEF]) begin
         t1_ff <= t1_in;
         t2_ff <= t2_in;
      end
      if (ctl.load[ST_PART]) begin
         pn_lo_ff <= PL_BITS'(t1_ff[T_LO-1:0]) * PL_BITS'(x_ff[ST_COEF]);
         pn_hi_ff <= PH_BITS'(t1_ff[T_BITS-1:T_LO]) * PH_BITS'(x_ff[ST_COEF]);
         pd_lo_ff <= PL_BITS'(t2_ff[T_LO-1:0]) * PL_BITS'(x_ff[ST_COEF]);
         pd_hi_ff <= PH_BITS'(t2_ff[T_BITS-1:T_LO]) * PH_BITS'(x_ff[ST_COEF]);
      end
   end

   always_comb begin
      if (mode == MODE_REINHARD) begin
         num_in     = P_BITS'(x_ff[ST_PART]);
         den_sum_in = (P_BITS'(1) << FRAC_BITS) + P_BITS'(x_ff[ST_PART]);
      end else begin
         num_in     = P_BITS'(pn_lo_ff) + (P_BITS'(pn_hi_ff) << T_LO);
         den_sum_in = P_BITS'(pd_lo_ff) + (P_BITS'(pd_hi_ff) << T_LO)
                    + (P_BITS'(ACES_E) << (2 * FRAC_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[ST_SUM]) begin
         num_ff     <= num_in;
         den_sum_ff <= den_sum_in;
      end
      if (ctl.load[ST_CMP]) begin
         rem_ff[0] <= num_ff;
         den_ff[0] <= den_sum_ff;
         q_ff[0]   <= '0;
         sat_ff[0] <= (num_ff >= den_sum_ff);
      end
   end

   for (genvar j = 1; j <= FRAC_BITS; j++) begin : g_div
      logic [P_BITS:0] shifted;
      logic [P_BITS:0] diff;
      logic            ge;

      assign shifted = {rem_ff[j-1], 1'b0};
      assign diff    = shifted - {1'b0, den_ff[j-1]};
      assign ge      = (shifted >= {1'b0, den_ff[j-1]});

      always_ff @(posedge clock) begin
         if (ctl.load[ST_CMP+j]) begin
            q_ff[j]   <= {q_ff[j-1][FRAC_BITS-2:0], ge};
            sat_ff[j] <= sat_ff[j-1];
         end
      end

      if (j < FRAC_BITS) begin : g_rem
         always_ff @(posedge clock) begin
            if (ctl.load[ST_CMP+j]) begin
               rem_ff[j] <= ge ? diff[P_BITS-1:0] : shifted[P_BITS-1:0];
               den_ff[j] <= den_ff[j-1];
            end
         end
      end
   end

   assign v_in   = sat_ff[FRAC_BITS] ? (ROM_BITS'(1) << FRAC_BITS)
                                     : ROM_BITS'(q_ff[FRAC_BITS]);
   assign pos    = POS_BITS'(v_in) << GAMMA_LUT_BITS;
   assign idx    = pos[POS_BITS-1:FRAC_BITS];
   assign idx_hi = (idx == IDX_BITS'(LUT_N)) ? idx : idx + IDX_BITS'(1);

   always_ff @(posedge clock) begin
      if (ctl.load[ST_ROM]) begin
         lo_ff <= GAMMA_ROM[idx];
         hi_ff <= GAMMA_ROM[idx_hi];
         f_ff  <= pos[FRAC_BITS-1:0];
      end
   end

   assign prod_in = PROD_BITS'(hi_ff - lo_ff) * PROD_BITS'(f_ff);

   always_ff @(posedge clock) begin
      if (ctl.load[ST_MUL]) begin
         base_ff <= lo_ff;
         prod_ff <= prod_in;
      end
      if (ctl.load[ST_ADD]) begin
         y_ff <= base_ff + prod_ff[PROD_BITS-1:FRAC_BITS];
      end
   end

   assign x_out = x_ff[NSTAGE-1];
   assign y_out = y_ff;

endmodule
`default_nettype wire

// ===== rtl/core/hdrtm_merge.sv =====
// Output register that gathers the three lanes into one result transaction.
`default_nettype none
module hdrtm_merge
   import hdrtm_pkg::*;
(
   input  wire logic                clock,
   input  wire hdrtm_ctl_type       ctl,
   input  wire logic [1:0]          mode,
   input  wire logic [CH_BITS-1:0]  x_lane [LANES],
   input  wire logic [ROM_BITS-1:0] y_lane [LANES],
   output hdrtm_rsp_type            rsp_payload
);

   logic               active;
   logic [CH_BITS-1:0] ch_in [LANES];
   hdrtm_rsp_type      rsp_ff;

   assign active = (mode == MODE_REINHARD) || (mode == MODE_ACES);

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         ch_in[k] = active ? CH_BITS'(y_lane[k]) : x_lane[k];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_ff.red_out   <= ch_in[0];
         rsp_ff.green_out <= ch_in[1];
         rsp_ff.blue_out  <= ch_in[2];
      end
   end

   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/core/hdr_tonemap_gamma.sv =====
// Top level of the HDR tonemapper with display gamma.
// One RGB pixel per clock is accepted and one result per clock is delivered, sustained
// while rsp_ready stays high; each channel has its own lane, and each lane holds the
// sixteen restoring divider steps plus the curve multipliers, the gamma table read and
// the interpolation multiply. Mode 0 (and the unused mode 3) passes the pixel through, mode 1
// applies Reinhard and mode 2 the ACES filmic curve, both followed by gamma 1/2.2. The mode
// register is written through csr_wr_en and csr_wr_data and must only be changed while no
// transaction is in flight.
`default_nettype none
module hdr_tonemap_gamma
   import hdrtm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire hdrtm_req_type req_payload,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output hdrtm_rsp_type      rsp_payload,
   input  wire logic          csr_wr_en,
   input  wire logic [1:0]    csr_wr_data
);

   logic [1:0]          tone_mode_ff;
   hdrtm_ctl_type       ctl;
   logic [CH_BITS-1:0]  x_in [LANES];
   logic [CH_BITS-1:0]  x_lane [LANES];
   logic [ROM_BITS-1:0] y_lane [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_mode_ff <= MODE_PASS;
      end else if (csr_wr_en) begin
         tone_mode_ff <= csr_wr_data;
      end
   end

   assign x_in[0] = req_payload.red_in;
   assign x_in[1] = req_payload.green_in;
   assign x_in[2] = req_payload.blue_in;

   hdrtm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      hdrtm_lane u_lane (
         .clock (clock),
         .ctl   (ctl),
         .mode  (tone_mode_ff),
         .x_in  (x_in[k]),
         .x_out (x_lane[k]),
         .y_out (y_lane[k])
      );
   end

   hdrtm_merge u_merge (
      .clock       (clock),
      .ctl         (ctl),
      .mode        (tone_mode_ff),
      .x_lane      (x_lane),
      .y_lane      (y_lane),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ===== rtl/core/hdrtm_checker.sv =====
// Port-level checker for the HDR tonemapper and its bind to the top level.
`default_nettype none
module hdrtm_checker
   import hdrtm_pkg::*;
(
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          req_valid,
   input wire logic          req_ready,
   input wire logic          rsp_valid,
   input wire logic          rsp_ready,
   input wire hdrtm_rsp_type rsp_payload,
   input wire logic          csr_wr_en,
   input wire logic [1:0]    csr_wr_data
);

   localparam logic [CH_BITS-1:0] ONE_FX = CH_BITS'(1) << FRAC_BITS;

   logic [1:0] mode_ff;
   logic [7:0] pending_ff;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_PASS;
         pending_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         pending_ff <= pending_ff + 8'(req_fire) - 8'(rsp_fire);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Result transaction changed while stalled.");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result valid right after reset.");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("Result transaction without an accepted request.");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (mode_ff == MODE_REINHARD || mode_ff == MODE_ACES) |->
         rsp_payload.red_out <= ONE_FX && rsp_payload.green_out <= ONE_FX
         && rsp_payload.blue_out <= ONE_FX)
      else $error("Tonemapped channel above one.");

endmodule

bind hdr_tonemap_gamma hdrtm_checker u_checker (.*);
`default_nettype wire
